// ===== src/rpr_pkg.sv =====
// Shared constants and stage-to-stage flag types for the rectangle pair relation unit.
`timescale 1ns / 1ps

package rpr_pkg;

  // Default coordinate width: signed Q11.4.
  localparam int COORD_BITS_DEF = 16;

  // Bit of the direction code that picks the axis: set selects x, clear selects y.
  localparam int DIR_AXIS_BIT = 0;

  // Flags leaving the first stage.
  typedef struct packed {
    logic overlaps;
    logic contained;
    logic strict;
    logic x_sel;
  } rpr_flags1_t;

  // Flags leaving the second stage.
  typedef struct packed {
    logic overlaps;
    logic contained;
    logic area_en;
  } rpr_flags2_t;

endpackage

// ===== src/rpr_bound.sv =====
// First stage: corner comparisons, overlap bounds, union, gaps and relation flags.
`timescale 1ns / 1ps

module rpr_bound
  import rpr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic signed [COORD_BITS-1:0] nxl,
  input  logic signed [COORD_BITS-1:0] nyl,
  input  logic signed [COORD_BITS-1:0] nxh,
  input  logic signed [COORD_BITS-1:0] nyh,
  input  logic signed [COORD_BITS-1:0] qxl,
  input  logic signed [COORD_BITS-1:0] qyl,
  input  logic signed [COORD_BITS-1:0] qxh,
  input  logic signed [COORD_BITS-1:0] qyh,
  input  logic [1:0]                   dir,
  output logic signed [COORD_BITS-1:0] lo_x,
  output logic signed [COORD_BITS-1:0] hi_x,
  output logic signed [COORD_BITS-1:0] lo_y,
  output logic signed [COORD_BITS-1:0] hi_y,
  output logic signed [COORD_BITS-1:0] ux_lo,
  output logic signed [COORD_BITS-1:0] uy_lo,
  output logic signed [COORD_BITS-1:0] ux_hi,
  output logic signed [COORD_BITS-1:0] uy_hi,
  output logic [COORD_BITS-1:0]        dx,
  output logic [COORD_BITS-1:0]        dy,
  output rpr_flags1_t                  flags
);

  logic [COORD_BITS:0] dx_a, dx_b, dy_a, dy_b;
  logic [COORD_BITS-1:0] dx_next, dy_next;
  rpr_flags1_t flags_next;

  // Differences are taken one bit wider; a chosen gap is always positive and fits.
  assign dx_a = {nxl[COORD_BITS-1], nxl} - {qxh[COORD_BITS-1], qxh};
  assign dx_b = {qxl[COORD_BITS-1], qxl} - {nxh[COORD_BITS-1], nxh};
  assign dy_a = {qyl[COORD_BITS-1], qyl} - {nyh[COORD_BITS-1], nyh};
  assign dy_b = {nyl[COORD_BITS-1], nyl} - {qyh[COORD_BITS-1], qyh};

  always_comb begin
    if (qxh < nxl) begin
      dx_next = dx_a[COORD_BITS-1:0];
    end else if (nxh < qxl) begin
      dx_next = dx_b[COORD_BITS-1:0];
    end else begin
      dx_next = '0;
    end
    if (nyh < qyl) begin
      dy_next = dy_a[COORD_BITS-1:0];
    end else if (qyh < nyl) begin
      dy_next = dy_b[COORD_BITS-1:0];
    end else begin
      dy_next = '0;
    end
    flags_next.overlaps  = !(nxl > qxh || qxl > nxh) && !(nyl > qyh || qyl > nyh);
    flags_next.contained = (nxl >= qxl) && (nxh <= qxh) && (nyl >= qyl) && (nyh <= qyh);
    flags_next.strict    = !(nxl >= qxh || qxl >= nxh) && !(nyl >= qyh || qyl >= nyh);
    flags_next.x_sel     = dir[DIR_AXIS_BIT];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lo_x  <= (nxl > qxl) ? nxl : qxl;
      hi_x  <= (nxh < qxh) ? nxh : qxh;
      lo_y  <= (nyl > qyl) ? nyl : qyl;
      hi_y  <= (nyh < qyh) ? nyh : qyh;
      ux_lo <= (nxl < qxl) ? nxl : qxl;
      uy_lo <= (nyl < qyl) ? nyl : qyl;
      ux_hi <= (nxh > qxh) ? nxh : qxh;
      uy_hi <= (nyh > qyh) ? nyh : qyh;
      dx    <= dx_next;
      dy    <= dy_next;
      flags <= flags_next;
    end
  end

endmodule

// ===== src/rpr_extent.sv =====
// Second stage: extents, doubled centres, edge overlap, Manhattan gap and squared gaps.
`timescale 1ns / 1ps

module rpr_extent
  import rpr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic signed [COORD_BITS-1:0] lo_x,
  input  logic signed [COORD_BITS-1:0] hi_x,
  input  logic signed [COORD_BITS-1:0] lo_y,
  input  logic signed [COORD_BITS-1:0] hi_y,
  input  logic [COORD_BITS-1:0]        dx,
  input  logic [COORD_BITS-1:0]        dy,
  input  rpr_flags1_t                  flags_in,
  output logic [COORD_BITS-1:0]        ext_x,
  output logic [COORD_BITS-1:0]        ext_y,
  output logic [COORD_BITS:0]          cx,
  output logic [COORD_BITS:0]          cy,
  output logic [COORD_BITS:0]          eo,
  output logic [COORD_BITS:0]          man,
  output logic [2*COORD_BITS-1:0]      dxx,
  output logic [2*COORD_BITS-1:0]      dyy,
  output rpr_flags2_t                  flags
);

  logic [COORD_BITS:0] ex, ey;
  logic                ex_pos, ey_pos;
  rpr_flags2_t         flags_next;

  assign ex = {hi_x[COORD_BITS-1], hi_x} - {lo_x[COORD_BITS-1], lo_x};
  assign ey = {hi_y[COORD_BITS-1], hi_y} - {lo_y[COORD_BITS-1], lo_y};
  assign ex_pos = !ex[COORD_BITS] && (|ex[COORD_BITS-1:0]);
  assign ey_pos = !ey[COORD_BITS] && (|ey[COORD_BITS-1:0]);

  always_comb begin
    flags_next.overlaps  = flags_in.overlaps;
    flags_next.contained = flags_in.contained;
    flags_next.area_en   = flags_in.strict && ex_pos && ey_pos;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ext_x <= ex[COORD_BITS-1:0];
      ext_y <= ey[COORD_BITS-1:0];
      cx    <= {lo_x[COORD_BITS-1], lo_x} + {hi_x[COORD_BITS-1], hi_x};
      cy    <= {lo_y[COORD_BITS-1], lo_y} + {hi_y[COORD_BITS-1], hi_y};
      eo    <= flags_in.x_sel ? ex : ey;
      man   <= {1'b0, dx} + {1'b0, dy};
      dxx   <= {{COORD_BITS{1'b0}}, dx} * {{COORD_BITS{1'b0}}, dx};
      dyy   <= {{COORD_BITS{1'b0}}, dy} * {{COORD_BITS{1'b0}}, dy};
      flags <= flags_next;
    end
  end

endmodule

// ===== src/rpr_finish.sv =====
// Third stage: overlap area product and squared Euclidean gap sum.
`timescale 1ns / 1ps

module rpr_finish
  import rpr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic [COORD_BITS-1:0]     ext_x,
  input  logic [COORD_BITS-1:0]     ext_y,
  input  logic [2*COORD_BITS-1:0]   dxx,
  input  logic [2*COORD_BITS-1:0]   dyy,
  input  logic                      area_en,
  output logic [2*COORD_BITS-1:0]   area,
  output logic [2*COORD_BITS:0]     sq
);

  localparam int SQ_W = 2 * COORD_BITS + 1;

  logic [2*COORD_BITS-1:0] prod;
  logic [SQ_W-1:0]         sum;
  logic [SQ_W-1:0]         sq_next;

  assign prod = {{COORD_BITS{1'b0}}, ext_x} * {{COORD_BITS{1'b0}}, ext_y};
  assign sum  = {1'b0, dxx} + {1'b0, dyy};

  // The sum is kept modulo 2^64, so any bit from 64 upwards reads as zero.
  always_comb begin
    for (int i = 0; i < SQ_W; i++) begin
      sq_next[i] = (i < 64) ? sum[i] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      area <= area_en ? prod : '0;
      sq   <= sq_next;
    end
  end

endmodule

// ===== src/rect_pair_relation_unit.sv =====
// Top level of the rectangle pair relation unit: three-stage pipeline and its flow control.
// The unit compares a node rectangle with a query rectangle and returns overlap and
// containment flags, the strict overlap area, the minimum squared Euclidean and Manhattan
// gaps, the doubled overlap centre, the bounding union and the overlap along the axis that
// edge_dir picks. It keeps no state between words. It takes one word per cycle unless
// in_stall is high. Each word passes through three register stages, the first of which
// loads at the edge that accepts the input: the first for the corner comparisons, the
// second for the extents and the squared gaps, the third for the area product and the
// gap sum. Each stage holds its word while the one after it is full and stalled, so a
// stall on the output fills the pipeline before in_stall rises, and no word is lost or
// repeated.
`timescale 1ns / 1ps

module rect_pair_relation_unit
  import rpr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] node_x_low,
  input  logic signed [COORD_BITS-1:0] node_y_low,
  input  logic signed [COORD_BITS-1:0] node_x_high,
  input  logic signed [COORD_BITS-1:0] node_y_high,
  input  logic signed [COORD_BITS-1:0] query_x_low,
  input  logic signed [COORD_BITS-1:0] query_y_low,
  input  logic signed [COORD_BITS-1:0] query_x_high,
  input  logic signed [COORD_BITS-1:0] query_y_high,
  input  logic [1:0]                   edge_dir,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         overlaps_flag,
  output logic                         inside_flag,
  output logic [2*COORD_BITS-1:0]      overlap_area,
  output logic [2*COORD_BITS:0]        min_sq_dist,
  output logic [COORD_BITS:0]          min_manhattan_dist,
  output logic signed [COORD_BITS:0]   center_x_doubled,
  output logic signed [COORD_BITS:0]   center_y_doubled,
  output logic signed [COORD_BITS-1:0] union_x_low,
  output logic signed [COORD_BITS-1:0] union_y_low,
  output logic signed [COORD_BITS-1:0] union_x_high,
  output logic signed [COORD_BITS-1:0] union_y_high,
  output logic signed [COORD_BITS:0]   edge_overlap
);

  // Stage valid bits and the per-stage load conditions.
  logic v1, v2, v3;
  logic v1_next, v2_next, v3_next;
  logic load1, load2, load3;

  // Stage 1 outputs.
  logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [COORD_BITS-1:0] s1_ux_lo, s1_uy_lo, s1_ux_hi, s1_uy_hi;
  logic [COORD_BITS-1:0]        dx, dy;
  rpr_flags1_t                  flags1;

  // Stage 2 outputs.
  logic [COORD_BITS-1:0]        ext_x, ext_y;
  logic [COORD_BITS:0]          s2_cx, s2_cy, s2_eo, s2_man;
  logic [2*COORD_BITS-1:0]      dxx, dyy;
  logic signed [COORD_BITS-1:0] s2_ux_lo, s2_uy_lo, s2_ux_hi, s2_uy_hi;
  rpr_flags2_t                  flags2;

  // A stage loads when it is empty or when the stage after it is loading as well.
  assign load3 = !v3 || !out_stall;
  assign load2 = !v2 || load3;
  assign load1 = !v1 || load2;

  assign in_stall  = !load1;
  assign out_valid = v3;

  assign v1_next = load1 ? in_valid : v1;
  assign v2_next = load2 ? v1 : v2;
  assign v3_next = load3 ? v2 : v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= v1_next;
      v2 <= v2_next;
      v3 <= v3_next;
    end
  end

  rpr_bound #(
    .COORD_BITS(COORD_BITS)
  ) u_bound (
    .clk   (clk),
    .load  (load1 && in_valid),
    .nxl   (node_x_low),
    .nyl   (node_y_low),
    .nxh   (node_x_high),
    .nyh   (node_y_high),
    .qxl   (query_x_low),
    .qyl   (query_y_low),
    .qxh   (query_x_high),
    .qyh   (query_y_high),
    .dir   (edge_dir),
    .lo_x  (lo_x),
    .hi_x  (hi_x),
    .lo_y  (lo_y),
    .hi_y  (hi_y),
    .ux_lo (s1_ux_lo),
    .uy_lo (s1_uy_lo),
    .ux_hi (s1_ux_hi),
    .uy_hi (s1_uy_hi),
    .dx    (dx),
    .dy    (dy),
    .flags (flags1)
  );

  rpr_extent #(
    .COORD_BITS(COORD_BITS)
  ) u_extent (
    .clk      (clk),
    .load     (load2 && v1),
    .lo_x     (lo_x),
    .hi_x     (hi_x),
    .lo_y     (lo_y),
    .hi_y     (hi_y),
    .dx       (dx),
    .dy       (dy),
    .flags_in (flags1),
    .ext_x    (ext_x),
    .ext_y    (ext_y),
    .cx       (s2_cx),
    .cy       (s2_cy),
    .eo       (s2_eo),
    .man      (s2_man),
    .dxx      (dxx),
    .dyy      (dyy),
    .flags    (flags2)
  );

  // The union corners need no arithmetic after the first stage and simply travel along.
  always_ff @(posedge clk) begin
    if (load2 && v1) begin
      s2_ux_lo <= s1_ux_lo;
      s2_uy_lo <= s1_uy_lo;
      s2_ux_hi <= s1_ux_hi;
      s2_uy_hi <= s1_uy_hi;
    end
  end

  rpr_finish #(
    .COORD_BITS(COORD_BITS)
  ) u_finish (
    .clk     (clk),
    .load    (load3 && v2),
    .ext_x   (ext_x),
    .ext_y   (ext_y),
    .dxx     (dxx),
    .dyy     (dyy),
    .area_en (flags2.area_en),
    .area    (overlap_area),
    .sq      (min_sq_dist)
  );

  // Output register for the fields that are already final after the second stage.
  always_ff @(posedge clk) begin
    if (load3 && v2) begin
      overlaps_flag      <= flags2.overlaps;
      inside_flag        <= flags2.contained;
      min_manhattan_dist <= s2_man;
      center_x_doubled   <= s2_cx;
      center_y_doubled   <= s2_cy;
      edge_overlap       <= s2_eo;
      union_x_low        <= s2_ux_lo;
      union_y_low        <= s2_uy_lo;
      union_x_high       <= s2_ux_hi;
      union_y_high       <= s2_uy_hi;
    end
  end

  // A free output side means the whole pipeline can move, so the input cannot be stalled.
  a_no_stall_when_drained : assert property (
    @(posedge clk) disable iff (rst) !out_stall |-> !in_stall
  ) else $error("input stalled although the output side is free");

  // A strict overlap area only arises where the rectangles also overlap inclusively.
  a_area_implies_overlap : assert property (
    @(posedge clk) disable iff (rst) (out_valid && overlap_area != '0) |-> overlaps_flag
  ) else $error("nonzero overlap area without overlap flag");

  // Overlapping rectangles have no gap on either axis.
  a_overlap_no_gap : assert property (
    @(posedge clk) disable iff (rst)
      (out_valid && overlaps_flag) |-> (min_manhattan_dist == '0 && min_sq_dist == '0)
  ) else $error("overlapping rectangles report a gap");

  // Both gap measures vanish together.
  a_gaps_agree : assert property (
    @(posedge clk) disable iff (rst)
      out_valid |-> ((min_manhattan_dist == '0) == (min_sq_dist == '0))
  ) else $error("Manhattan and squared gaps disagree on zero");

endmodule
